// File: src/lcrh_pkg.sv
// shared types, constants and the sine table for the crossfading loop record head
package lcrh_pkg;

  localparam int unsigned BUFFER_FRAMES   = 65536;
  localparam int unsigned AW              = $clog2(BUFFER_FRAMES);
  localparam int unsigned SINE_TABLE_SIZE = 1024;
  localparam int unsigned SW              = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned FW              = 25;
  localparam logic [FW-1:0] FADE_ONE      = 25'h1000000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DW    = 32;

  localparam int unsigned FLAG_LOOP = 0;
  localparam int unsigned FLAG_REC  = 1;
  localparam int unsigned FLAG_EQ   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE       = 4'd0,
    CFG_LOOP_START = 4'd1,
    CFG_LOOP_END   = 4'd2,
    CFG_FADE_STEP  = 4'd3,
    CFG_REC_LEVEL  = 4'd4,
    CFG_PRE_LEVEL  = 4'd5,
    CFG_SHAPING    = 4'd6,
    CFG_FLAGS      = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HM_INACTIVE,
    HM_FADEIN,
    HM_ACTIVE,
    HM_FADEOUT
  } head_mode_e;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_RD_TAP,
    MEM_RD_W0,
    MEM_RD_W1,
    MEM_WR_W0,
    MEM_WR_W1
  } mem_op_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_C3F,
    MUL_TF,
    MUL_DFR,
    MUL_RG,
    MUL_RECFR,
    MUL_CUT,
    MUL_NFPRE,
    MUL_FPRE,
    MUL_NFRG,
    MUL_FRG,
    MUL_XP,
    MUL_OLDG
  } mul_op_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_T1,
    OP_T2,
    OP_RES,
    OP_GLIN,
    OP_GROM,
    OP_GSUM,
    OP_ACC0,
    OP_ACC1,
    OP_OUT,
    OP_RG,
    OP_GW0,
    OP_GW1,
    OP_ACCW
  } dp_op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CUT,
    S_ADV,
    S_RAMP,
    S_RD,
    S_RDW,
    S_C3,
    S_T1,
    S_M2,
    S_T2,
    S_M3,
    S_RES,
    S_GRD,
    S_GMUL,
    S_GSUM,
    S_MX0,
    S_MX1,
    S_MX2,
    S_OUT,
    S_W0,
    S_W1,
    S_W2,
    S_W3,
    S_W4,
    S_W5,
    S_W6,
    S_W7,
    S_W8,
    S_W9,
    S_W10,
    S_W11
  } ctl_state_e;

  typedef struct packed {
    logic       in_load;
    logic       cut;
    logic       adv;
    logic       ramp;
    logic       head;
    logic [1:0] tap;
    mem_op_e    mem_op;
    mul_op_e    mul_op;
    dp_op_e     op;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       eq;
    logic       rec_run;
    logic [1:0] wr_en;
  } stat_t;

  typedef logic [FW-1:0] sine_rom_t [SINE_TABLE_SIZE+1];

  // shift and subtract quotient, only used while building the table
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t       tbl;
    longint unsigned th;
    longint unsigned term;
    longint          sum;
    longint          v;
    for (int k = 0; k <= int'(SINE_TABLE_SIZE); k++) begin
      th   = (HALF_PI_Q30 * longint'(k)) >> SW;
      term = th;
      sum  = longint'(th);
      for (int i = 1; i <= 7; i++) begin
        term = (((term * th) >> 30) * th) >> 30;
        term = udiv(term, 64'((2 * i) * (2 * i + 1)));
        if ((i & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      v = (sum >= 0) ? ((sum + 32) >>> 6) : 64'sd0;
      if (v > longint'(FADE_ONE)) begin
        v = longint'(FADE_ONE);
      end
      tbl[k] = v[FW-1:0];
    end
    return tbl;
  endfunction

endpackage

// File: src/lcrh_ctrl.sv
// sequencer for memory clear, tick, cut, interpolated reads, mix and overdub writes
module lcrh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_mode_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output lcrh_pkg::cmd_t  cmd_o,
  input  lcrh_pkg::stat_t stat_i
);
  import lcrh_pkg::*;

  ctl_state_e state_q, state_d;
  logic       head_q, head_d;
  logic [1:0] tap_q, tap_d;
  logic       ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      head_q  <= 1'b0;
      tap_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tap_q   <= tap_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tap_d      = tap_q;
    ov_d       = ov_q & ~out_ready_i;
    in_ready_o = 1'b0;
    cmd_o         = '0;
    cmd_o.head    = head_q;
    cmd_o.tap     = tap_q;
    cmd_o.mem_op  = MEM_IDLE;
    cmd_o.mul_op  = MUL_NONE;
    cmd_o.op      = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_op = MEM_CLEAR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        head_d     = 1'b0;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = in_mode_i ? S_CUT : S_ADV;
        end
      end
      S_CUT: begin
        cmd_o.cut = 1'b1;
        state_d   = S_IDLE;
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        head_d    = ~head_q;
        if (head_q) begin
          state_d = S_RAMP;
        end
      end
      S_RAMP: begin
        cmd_o.ramp = 1'b1;
        tap_d      = '0;
        state_d    = S_RD;
      end
      S_RD: begin
        cmd_o.mem_op = MEM_RD_TAP;
        tap_d        = tap_q + 2'd1;
        if (tap_q == 2'd3) begin
          state_d = S_RDW;
        end
      end
      S_RDW: state_d = S_C3;
      S_C3: begin
        cmd_o.mul_op = MUL_C3F;
        state_d      = S_T1;
      end
      S_T1: begin
        cmd_o.op = OP_T1;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.mul_op = MUL_TF;
        state_d      = S_T2;
      end
      S_T2: begin
        cmd_o.op = OP_T2;
        state_d  = S_M3;
      end
      S_M3: begin
        cmd_o.mul_op = MUL_TF;
        state_d      = S_RES;
      end
      S_RES: begin
        cmd_o.op = OP_RES;
        head_d   = ~head_q;
        state_d  = head_q ? S_GRD : S_RD;
      end
      S_GRD: begin
        if (stat_i.eq) begin
          cmd_o.op = OP_GROM;
          state_d  = S_GMUL;
        end else begin
          cmd_o.op = OP_GLIN;
          head_d   = ~head_q;
          if (head_q) begin
            state_d = S_MX0;
          end
        end
      end
      S_GMUL: begin
        cmd_o.mul_op = MUL_DFR;
        state_d      = S_GSUM;
      end
      S_GSUM: begin
        cmd_o.op = OP_GSUM;
        head_d   = ~head_q;
        state_d  = head_q ? S_MX0 : S_GRD;
      end
      S_MX0: begin
        cmd_o.head   = 1'b0;
        cmd_o.mul_op = MUL_RG;
        state_d      = S_MX1;
      end
      S_MX1: begin
        cmd_o.head   = 1'b1;
        cmd_o.mul_op = MUL_RG;
        cmd_o.op     = OP_ACC0;
        state_d      = S_MX2;
      end
      S_MX2: begin
        cmd_o.op = OP_ACC1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        head_d = 1'b0;
        if (!ov_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          ov_d     = 1'b1;
          state_d  = stat_i.rec_run ? S_W0 : S_IDLE;
        end
      end
      S_W0: begin
        if (stat_i.wr_en[head_q]) begin
          cmd_o.mul_op = MUL_RECFR;
          state_d      = S_W1;
        end else begin
          head_d  = ~head_q;
          state_d = head_q ? S_IDLE : S_W0;
        end
      end
      S_W1: begin
        cmd_o.mul_op = MUL_CUT;
        state_d      = S_W2;
      end
      S_W2: begin
        cmd_o.op     = OP_RG;
        cmd_o.mul_op = MUL_NFPRE;
        cmd_o.mem_op = MEM_RD_W0;
        state_d      = S_W3;
      end
      S_W3: begin
        cmd_o.op     = OP_GW0;
        cmd_o.mul_op = MUL_NFRG;
        state_d      = S_W4;
      end
      S_W4: begin
        cmd_o.mul_op = MUL_XP;
        state_d      = S_W5;
      end
      S_W5: begin
        cmd_o.op     = OP_ACCW;
        cmd_o.mul_op = MUL_OLDG;
        state_d      = S_W6;
      end
      S_W6: begin
        cmd_o.mem_op = MEM_WR_W0;
        state_d      = S_W7;
      end
      S_W7: begin
        cmd_o.mem_op = MEM_RD_W1;
        cmd_o.mul_op = MUL_FPRE;
        state_d      = S_W8;
      end
      S_W8: begin
        cmd_o.op     = OP_GW1;
        cmd_o.mul_op = MUL_FRG;
        state_d      = S_W9;
      end
      S_W9: begin
        cmd_o.mul_op = MUL_XP;
        state_d      = S_W10;
      end
      S_W10: begin
        cmd_o.op     = OP_ACCW;
        cmd_o.mul_op = MUL_OLDG;
        state_d      = S_W11;
      end
      S_W11: begin
        cmd_o.mem_op = MEM_WR_W1;
        head_d       = ~head_q;
        state_d      = head_q ? S_IDLE : S_W0;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: src/lcrh_dp.sv
// head state, config registers, sample memory, shared multiplier and result registers
module lcrh_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcrh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcrh_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic signed [23:0]             audio_in_i,
  input  lcrh_pkg::cmd_t                 cmd_i,
  output lcrh_pkg::stat_t                stat_o,
  output logic signed [33:0]             position_o,
  output logic [1:0]                     trigger_o,
  output logic signed [23:0]             audio_out_o
);
  import lcrh_pkg::*;

  localparam int unsigned TW = 30;
  localparam int unsigned MA = 34;
  localparam int unsigned MB = 34;
  localparam int unsigned PW = MA + MB + 1;
  localparam sine_rom_t SineRom = build_sine();

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    logic signed [23:0] r;
    if (v > 36'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -36'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // configuration
  logic signed [23:0] rate_q;
  logic [31:0]        loop_start_q, loop_end_q;
  logic [FW-1:0]      fade_step_q;
  logic [16:0]        rec_q, pre_q;
  logic [15:0]        fr_q;
  logic [2:0]         flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= '0;
      loop_start_q <= '0;
      loop_end_q   <= '0;
      fade_step_q  <= 25'd3804;
      rec_q        <= '0;
      pre_q        <= '0;
      fr_q         <= '0;
      flags_q      <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE:       rate_q       <= cfg_data_i[23:0];
        CFG_LOOP_START: loop_start_q <= cfg_data_i;
        CFG_LOOP_END:   loop_end_q   <= cfg_data_i;
        CFG_FADE_STEP:  fade_step_q  <= cfg_data_i[FW-1:0];
        CFG_REC_LEVEL:  rec_q        <= cfg_data_i[16:0];
        CFG_PRE_LEVEL:  pre_q        <= cfg_data_i[16:0];
        CFG_SHAPING:    fr_q         <= cfg_data_i[31:16];
        CFG_FLAGS:      flags_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // head state
  logic signed [33:0] phase_q [2];
  logic signed [33:0] phase_d [2];
  logic [FW-1:0]      fade_q [2];
  logic [FW-1:0]      fade_d [2];
  head_mode_e         mode_q [2];
  head_mode_e         mode_d [2];
  logic               active_q, active_d;
  logic [1:0]         trig_q, trig_d;

  logic               h;
  logic signed [33:0] hph;
  logic signed [33:0] adv_p;
  logic               out_win;
  logic               rate_pos;
  logic               do_cut;
  logic signed [33:0] cut_tgt;
  logic [FW:0]        up_s, dn_s;

  assign h        = cmd_i.head;
  assign hph      = phase_q[h];
  assign adv_p    = hph + 34'(rate_q);
  assign out_win  = (adv_p > $signed({2'b00, loop_end_q}))
                 || (adv_p < $signed({2'b00, loop_start_q}));
  assign rate_pos = !rate_q[23] && (rate_q != 24'sd0);

  always_comb begin
    phase_d  = phase_q;
    fade_d   = fade_q;
    mode_d   = mode_q;
    active_d = active_q;
    trig_d   = trig_q;
    do_cut   = 1'b0;
    cut_tgt  = $signed({2'b00, loop_start_q});
    up_s     = '0;
    dn_s     = '0;
    if (cmd_i.cut) begin
      do_cut = 1'b1;
    end
    if (cmd_i.adv) begin
      trig_d[h] = 1'b0;
      if (mode_q[h] != HM_INACTIVE) begin
        if ((h == active_q) && out_win) begin
          if (flags_q[FLAG_LOOP]) begin
            do_cut    = 1'b1;
            cut_tgt   = rate_pos ? $signed({2'b00, loop_start_q})
                                 : $signed({2'b00, loop_end_q});
            trig_d[h] = 1'b1;
          end else begin
            mode_d[h] = HM_FADEOUT;
          end
        end
        phase_d[h] = adv_p;
      end
    end
    if (do_cut && (mode_q[active_q] != HM_FADEIN) && (mode_q[active_q] != HM_FADEOUT)) begin
      if (mode_q[active_q] != HM_INACTIVE) begin
        mode_d[active_q] = HM_FADEOUT;
      end
      mode_d[~active_q]  = HM_FADEIN;
      phase_d[~active_q] = cut_tgt;
      active_d           = ~active_q;
    end
    if (cmd_i.ramp) begin
      for (int i = 0; i < 2; i++) begin
        up_s = {1'b0, fade_q[i]} + {1'b0, fade_step_q};
        dn_s = {1'b0, fade_q[i]} - {1'b0, fade_step_q};
        if (mode_q[i] == HM_FADEIN) begin
          if (up_s > {1'b0, FADE_ONE}) begin
            fade_d[i] = FADE_ONE;
            mode_d[i] = HM_ACTIVE;
          end else begin
            fade_d[i] = up_s[FW-1:0];
          end
        end else if (mode_q[i] == HM_FADEOUT) begin
          if (dn_s[FW]) begin
            fade_d[i] = '0;
            mode_d[i] = HM_INACTIVE;
          end else begin
            fade_d[i] = dn_s[FW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        phase_q[i] <= '0;
        fade_q[i]  <= '0;
        mode_q[i]  <= HM_INACTIVE;
      end
      active_q <= 1'b0;
      trig_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      fade_q   <= fade_d;
      mode_q   <= mode_d;
      active_q <= active_d;
      trig_q   <= trig_d;
    end
  end

  // sample memory
  logic signed [23:0] mem_q [BUFFER_FRAMES];
  logic signed [23:0] rdata_q;
  logic [AW-1:0]      clr_q;
  logic [AW-1:0]      base;
  logic [AW-1:0]      mem_addr;
  logic               mem_we, mem_re;
  logic signed [23:0] mem_wdata;
  logic signed [23:0] wsat;
  logic               pend_q;
  logic [1:0]         ptap_q;
  logic signed [23:0] y_q [4];

  assign base = hph[16 +: AW];

  always_comb begin
    mem_addr  = base;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = wsat;
    unique case (cmd_i.mem_op)
      MEM_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      MEM_RD_TAP: begin
        mem_addr = base + AW'(cmd_i.tap) - AW'(1);
        mem_re   = 1'b1;
      end
      MEM_RD_W0: mem_re = 1'b1;
      MEM_RD_W1: begin
        mem_addr = base + AW'(1);
        mem_re   = 1'b1;
      end
      MEM_WR_W0: mem_we = 1'b1;
      MEM_WR_W1: begin
        mem_addr = base + AW'(1);
        mem_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
    ptap_q <= cmd_i.tap;
    if (pend_q) begin
      y_q[ptap_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= (cmd_i.mem_op == MEM_RD_TAP);
      if (cmd_i.mem_op == MEM_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // cubic coefficients
  logic signed [27:0] c1, c2, c3;
  assign c1 = 28'(y_q[2]) - 28'(y_q[0]);
  assign c2 = 28'(y_q[0]) * 28'sd2 - 28'(y_q[1]) * 28'sd5 + 28'(y_q[2]) * 28'sd4 - 28'(y_q[3]);
  assign c3 = (28'(y_q[3]) - 28'(y_q[0])) + (28'(y_q[1]) - 28'(y_q[2])) * 28'sd3;

  // shared multiplier
  logic signed [PW-1:0] prod_q;
  logic signed [MA-1:0] mul_a;
  logic [MB-1:0]        mul_b;
  logic [16:0]          hf, nf;
  logic signed [TW-1:0] t_q;
  logic signed [TW-1:0] r_q [2];
  logic [FW-1:0]        g_q [2];
  logic [FW-1:0]        rom_lo_q, rom_hi_q;
  logic [SW:0]          gi, gi1;
  logic [23:0]          gfr;
  logic signed [FW:0]   gdiff;
  logic signed [57:0]   acc_q;
  logic [16:0]          rg_q;
  logic [MB-1:0]        gw_q;
  logic signed [59:0]   accw_q;
  logic signed [59:0]   wsum;
  logic signed [23:0]   x_q;

  assign hf    = {1'b0, hph[15:0]};
  assign nf    = 17'h10000 - hf;
  assign gi    = fade_q[h][FW-1 -: SW+1];
  assign gi1   = (gi == (SW+1)'(SINE_TABLE_SIZE)) ? gi : gi + (SW+1)'(1);
  assign gfr   = {fade_q[h][FW-2-SW:0], {SW{1'b0}}};
  assign gdiff = $signed({1'b0, rom_hi_q}) - $signed({1'b0, rom_lo_q});
  assign wsum  = prod_q[59:0] + accw_q + 60'sd2147483648;
  assign wsat  = sat24(36'(wsum >>> 32));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_C3F: begin
        mul_a = MA'(c3);
        mul_b = MB'(hf);
      end
      MUL_TF: begin
        mul_a = MA'(t_q);
        mul_b = MB'(hf);
      end
      MUL_DFR: begin
        mul_a = MA'(gdiff);
        mul_b = MB'(gfr);
      end
      MUL_RG: begin
        mul_a = MA'(r_q[h]);
        mul_b = MB'(g_q[h]);
      end
      MUL_RECFR: begin
        mul_a = $signed(MA'(rec_q));
        mul_b = MB'(fr_q);
      end
      MUL_CUT: begin
        mul_a = $signed({1'b0, prod_q[32:0]});
        mul_b = MB'(FADE_ONE - fade_q[h]);
      end
      MUL_NFPRE: begin
        mul_a = $signed(MA'(nf));
        mul_b = MB'(pre_q);
      end
      MUL_FPRE: begin
        mul_a = $signed(MA'(hf));
        mul_b = MB'(pre_q);
      end
      MUL_NFRG: begin
        mul_a = $signed(MA'(nf));
        mul_b = MB'(rg_q);
      end
      MUL_FRG: begin
        mul_a = $signed(MA'(hf));
        mul_b = MB'(rg_q);
      end
      MUL_XP: begin
        mul_a = MA'(x_q);
        mul_b = prod_q[MB-1:0];
      end
      MUL_OLDG: begin
        mul_a = MA'(rdata_q);
        mul_b = gw_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= mul_a * $signed({1'b0, mul_b});
    end
    if (cmd_i.in_load) begin
      x_q <= audio_in_i;
    end
    unique case (cmd_i.op)
      OP_T1:   t_q <= TW'(prod_q >>> 16) + TW'(c2);
      OP_T2:   t_q <= TW'(prod_q >>> 16) + TW'(c1);
      OP_RES:  r_q[h] <= TW'(y_q[1]) + (TW'(prod_q >>> 16) >>> 1);
      OP_GLIN: g_q[h] <= fade_q[h];
      OP_GROM: begin
        rom_lo_q <= SineRom[gi];
        rom_hi_q <= SineRom[gi1];
      end
      OP_GSUM: g_q[h] <= rom_lo_q + FW'(prod_q >>> 24);
      OP_ACC0: acc_q <= prod_q[57:0];
      OP_ACC1: acc_q <= acc_q + prod_q[57:0];
      OP_OUT: begin
        position_o  <= phase_q[active_q];
        trigger_o   <= 2'(trig_q[0]) + 2'(trig_q[1]);
        audio_out_o <= sat24(36'(acc_q >>> 24));
      end
      OP_RG:   rg_q <= rec_q - prod_q[56:40];
      OP_GW0:  gw_q <= MB'({hf[15:0], 16'h0000}) + prod_q[MB-1:0];
      OP_GW1:  gw_q <= MB'({nf, 16'h0000}) + prod_q[MB-1:0];
      OP_ACCW: accw_q <= prod_q[59:0];
      default: ;
    endcase
  end

  assign stat_o.clr_last = (clr_q == {AW{1'b1}});
  assign stat_o.eq       = flags_q[FLAG_EQ];
  assign stat_o.rec_run  = flags_q[FLAG_REC];
  assign stat_o.wr_en[0] = (fade_q[0] >= FW'(2)) && (rec_q != '0);
  assign stat_o.wr_en[1] = (fade_q[1] >= FW'(2)) && (rec_q != '0);

endmodule

// File: src/looping_crossfade_record_head_core.sv
// Two-head crossfading loop sampler voice with overdub recording, top level.
// A tick item gives its result after tap reads, interpolation, gains and mix,
// later with equal-power than with linear fades; with record run each head
// then writes its overdub or skips, and a result stall holds the tick. Items are
// taken one at a time, due to the single memory port and the shared multiplier.
// After reset all 65536 sample frames are cleared with s_axis_tready low.
module looping_crossfade_record_head_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcrh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcrh_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // audio_in
  input  logic                           s_axis_tuser,  // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [63:0]                    m_axis_tdata   // position, trigger, audio_out
);
  import lcrh_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic signed [33:0] position;
  logic [1:0]         trigger;
  logic signed [23:0] audio_out;

  lcrh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  lcrh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .audio_in_i  ($signed(s_axis_tdata)),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .position_o  (position),
    .trigger_o   (trigger),
    .audio_out_o (audio_out)
  );

  assign m_axis_tdata = {4'b0000, audio_out, trigger, position};

endmodule

// File: src/lcrh_checker.sv
// port-level checks for the loop record head core and their binding
module lcrh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  // at most two heads wrap in one tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[35:34] != 2'd3)
    else $error("trigger count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind looping_crossfade_record_head_core lcrh_checker u_lcrh_checker (.*);
